// ===== sv/bmp_grayscale_threshold_stream_top_defines.svh =====
// Assertion macros shared by the checker of the BMP filter stream.
`ifndef BMP_GRAYSCALE_THRESHOLD_STREAM_TOP_DEFINES_SVH
`define BMP_GRAYSCALE_THRESHOLD_STREAM_TOP_DEFINES_SVH

// Clocked check, silenced while reset is high.
`define BGT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds across reset.
`define BGT_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/bgt_pkg.sv =====
// Types, constants and the divide-by-three helper of the BMP filter stream.
package bgt_pkg;

   // Header field locations and limits
   localparam int unsigned COUNTER_BITS_DEF = 32;
   localparam int unsigned OFFSET_BASE      = 10;
   localparam int unsigned WIDTH_BASE       = 18;
   localparam int unsigned HEIGHT_BASE      = 22;
   localparam logic [31:0] MIN_OFFSET       = 32'd26;

   // Result queue depth; an input beat may add up to three output beats
   localparam int unsigned FIFO_DEPTH = 8;
   localparam int unsigned MAX_PUSH   = 3;

   // Output levels of threshold mode
   localparam logic [7:0] LEVEL_BLACK = 8'd0;
   localparam logic [7:0] LEVEL_WHITE = 8'd255;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } beat_type;

   // Output beats produced by one input beat
   typedef struct packed {
      logic [1:0]         count;
      beat_type [2:0]     beat;
   } result_type;

   // floor(sum / 3) for sum up to 765: multiply by 683 / 2048
   function automatic logic [7:0] div3(input logic [9:0] sum);
      logic [19:0] prod;
      prod = 20'(sum) * 20'd683;
      return prod[18:11];
   endfunction

endpackage

// ===== sv/bgt_core.sv =====
// Header capture, pixel gathering and per-beat filter decision.
module bgt_core
   import bgt_pkg::*;
#(
   parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       beat_en,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic       csr_wr_en,
   input  logic       csr_grayscale_mode,
   output result_type result
);

   localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

   logic                    mode_ff;
   logic [COUNTER_BITS-1:0] pos_ff, pos_in;
   logic [31:0]             offset_ff, offset_in;
   logic [31:0]             width_ff, width_in;
   logic [31:0]             height_ff, height_in;
   logic [7:0]              blue_ff, blue_in;
   logic [7:0]              green_ff, green_in;
   logic [1:0]              chan_ff, chan_in;
   logic [COUNTER_BITS-1:0] col_ff, col_in;
   logic [COUNTER_BITS-1:0] row_ff, row_in;
   logic [1:0]              pad_ff, pad_in;

   logic                    hdr_ok;
   logic                    active;
   logic [9:0]              sum;
   logic [7:0]              mean;
   logic [7:0]              level;
   logic [COUNTER_BITS-1:0] col_inc;

   function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
      return (v == CNT_MAX) ? v : v + COUNTER_BITS'(1);
   endfunction

   // Replace one byte lane of a little-endian field when pos falls in it
   function automatic logic [31:0] capture(
      input logic [31:0]             field,
      input logic [COUNTER_BITS-1:0] pos,
      input int unsigned             base,
      input logic [7:0]              b
   );
      logic [31:0] f;
      logic [1:0]  lane;
      f    = field;
      lane = 2'(pos - COUNTER_BITS'(base));
      if (pos >= COUNTER_BITS'(base) && pos <= COUNTER_BITS'(base + 3)) begin
         case (lane)
            2'd0:    f[7:0]   = b;
            2'd1:    f[15:8]  = b;
            2'd2:    f[23:16] = b;
            default: f[31:24] = b;
         endcase
      end
      return f;
   endfunction

   // Pixel mean and optional black/white threshold
   assign sum     = 10'(blue_ff) + 10'(green_ff) + 10'(in_byte);
   assign mean    = div3(sum);
   assign level   = mode_ff ? mean : (mean[7] ? LEVEL_WHITE : LEVEL_BLACK);
   assign col_inc = sat_inc(col_ff);

   // Header sanity and pixel region check
   assign hdr_ok = (offset_ff >= MIN_OFFSET)
                && (width_ff != '0) && !width_ff[31]
                && (height_ff != '0) && !height_ff[31];
   assign active = hdr_ok && (32'(pos_ff) >= offset_ff) && (32'(row_ff) < height_ff);

   // Decide the output beats and the next state for the current input beat
   always_comb begin
      result    = '0;
      pos_in    = pos_ff;
      offset_in = offset_ff;
      width_in  = width_ff;
      height_in = height_ff;
      blue_in   = blue_ff;
      green_in  = green_ff;
      chan_in   = chan_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pad_in    = pad_ff;

      if (!active) begin
         offset_in            = capture(offset_ff, pos_ff, OFFSET_BASE, in_byte);
         width_in             = capture(width_ff, pos_ff, WIDTH_BASE, in_byte);
         height_in            = capture(height_ff, pos_ff, HEIGHT_BASE, in_byte);
         result.count         = 2'd1;
         result.beat[0].data  = in_byte;
         result.beat[0].last  = in_last;
      end else if (pad_ff != 2'd0) begin
         // Row padding passes through
         result.count         = 2'd1;
         result.beat[0].data  = in_byte;
         result.beat[0].last  = in_last;
         pad_in               = pad_ff - 2'd1;
         if (pad_ff == 2'd1) begin
            row_in = sat_inc(row_ff);
         end
      end else if (chan_ff == 2'd0) begin
         if (in_last) begin
            result.count        = 2'd1;
            result.beat[0].data = in_byte;
            result.beat[0].last = 1'b1;
         end else begin
            blue_in = in_byte;
            chan_in = 2'd1;
         end
      end else if (chan_ff == 2'd1) begin
         if (in_last) begin
            // Flush the partial pixel
            result.count        = 2'd2;
            result.beat[0].data = blue_ff;
            result.beat[0].last = 1'b0;
            result.beat[1].data = in_byte;
            result.beat[1].last = 1'b1;
         end else begin
            green_in = in_byte;
            chan_in  = 2'd2;
         end
      end else begin
         // Complete pixel: three equal bytes
         result.count        = 2'd3;
         result.beat[0].data = level;
         result.beat[0].last = 1'b0;
         result.beat[1].data = level;
         result.beat[1].last = 1'b0;
         result.beat[2].data = level;
         result.beat[2].last = in_last;
         chan_in             = 2'd0;
         if (32'(col_inc) == width_ff) begin
            col_in = '0;
            pad_in = width_ff[1:0];
            if (width_ff[1:0] == 2'd0) begin
               row_in = sat_inc(row_ff);
            end
         end else begin
            col_in = col_inc;
         end
      end

      // End of file: return to the idle state, ready for the next file
      if (in_last) begin
         pos_in    = '0;
         offset_in = '0;
         width_in  = '0;
         height_in = '0;
         blue_in   = '0;
         green_in  = '0;
         chan_in   = '0;
         col_in    = '0;
         row_in    = '0;
         pad_in    = '0;
      end else begin
         pos_in = sat_inc(pos_ff);
      end
   end

   // Advance state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         offset_ff <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         blue_ff   <= '0;
         green_ff  <= '0;
         chan_ff   <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         pad_ff    <= '0;
      end else if (beat_en) begin
         pos_ff    <= pos_in;
         offset_ff <= offset_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         blue_ff   <= blue_in;
         green_ff  <= green_in;
         chan_ff   <= chan_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pad_ff    <= pad_in;
      end
   end

   // Hold the mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         mode_ff <= csr_grayscale_mode;
      end
   end

endmodule

// ===== sv/bgt_fifo.sv =====
// Result queue: takes up to three beats at once, drains one per ready cycle.
module bgt_fifo
   import bgt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_en,
   input  result_type push,
   output logic       has_room,
   output logic       out_valid,
   input  logic       out_ready,
   output beat_type   out_beat
);

   localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

   beat_type         mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] push_n;
   logic             pop;

   assign out_valid = (cnt_ff != '0);
   assign out_beat  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign has_room  = (cnt_ff <= CNT_W'(FIFO_DEPTH - MAX_PUSH));
   assign push_n    = push_en ? CNT_W'(push.count) : '0;

   // Advance pointers and occupancy
   always_comb begin
      rd_in  = pop ? rd_ff + PTR_W'(1) : rd_ff;
      wr_in  = wr_ff + PTR_W'(push_n);
      cnt_in = cnt_ff + push_n - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   // Write the new beats at consecutive slots
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_PUSH; k++) begin
         if (CNT_W'(k) < push_n) begin
            mem_ff[wr_ff + PTR_W'(k)] <= push.beat[k];
         end
      end
   end

endmodule

// ===== sv/bmp_grayscale_threshold_stream_top.sv =====
// Top level of the BMP grayscale / threshold byte stream filter.
//
//   port group  direction  handshake        payload
//   req_        in         valid / ready    in_byte, in_last
//   rsp_        out        valid / ready    out_byte, out_last
//   csr_        in         write enable     grayscale_mode
//
// One byte is accepted per cycle while req_ready is high; its zero to three beats
// enter an eight-entry queue the same edge and leave one per cycle on rsp_ready.
// Sustained rate is one byte per cycle each way, set by the single queue read port.
// req_ready drops only while the queue holds more than five beats.
// Synchronous reset empties the queue and clears all parse state and the mode bit.
module bmp_grayscale_threshold_stream_top
   import bgt_pkg::*;
#(
   parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   input  logic       csr_wr_en,
   input  logic       csr_grayscale_mode
);

   logic       beat_en;
   result_type result;
   beat_type   head;

   assign beat_en = req_valid && req_ready;

   bgt_core #(
      .COUNTER_BITS(COUNTER_BITS)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .beat_en            (beat_en),
      .in_byte            (req_in_byte),
      .in_last            (req_in_last),
      .csr_wr_en          (csr_wr_en),
      .csr_grayscale_mode (csr_grayscale_mode),
      .result             (result)
   );

   bgt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (beat_en),
      .push      (result),
      .has_room  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_beat  (head)
   );

   assign rsp_out_byte = head.data;
   assign rsp_out_last = head.last;

endmodule

// ===== sv/bgt_checker.sv =====
// Port-level checks of the BMP filter stream and their bind to the top level.
`include "bmp_grayscale_threshold_stream_top_defines.svh"

module bgt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last
);

   logic [8:0] rsp_payload;

   assign rsp_payload = {rsp_out_byte, rsp_out_last};

   // Result beat stays offered until taken
   `BGT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp_valid dropped while stalled")

   // Stalled result payload does not move
   `BGT_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_payload), "rsp payload moved")

   // Empty output side always leaves room for a new byte
   `BGT_ASSERT(a_idle_ready, !rsp_valid |-> req_ready, "req_ready low with no pending result")

   // Reset empties the queue and opens the input
   `BGT_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid && req_ready, "queue not empty after reset")

endmodule

bind bmp_grayscale_threshold_stream_top bgt_checker u_bgt_checker (.*);
